/* sv/sticky_least_loaded_assign_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the sticky least-loaded assignment block
// Clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef STICKY_LEAST_LOADED_ASSIGN_ASSERT_SVH
`define STICKY_LEAST_LOADED_ASSIGN_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define SLLA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the cycle after the trigger
`define SLLA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/slla_pkg.sv */
// ---------------------------------------------------------------------------
// slla_pkg
// Shared constants, state encoding and controller/datapath interface types.
// ---------------------------------------------------------------------------
package slla_pkg;

    // key table geometry, fixed by the key_slot field width
    localparam int SLOT_W    = 10;
    localparam int KEY_SLOTS = 1 << SLOT_W;

    // field widths
    localparam int LEN_W     = 32;
    localparam int CFG_W     = 4;
    localparam int OUT_ENG_W = 3;

    // controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_SCAN,
        ST_UPDATE
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic clr_wr;
        logic accept;
        logic post_hit;
        logic post_miss;
        logic scan_init;
        logic scan_step;
        logic commit;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic clr_last;
        logic entry_valid;
        logic len_zero;
        logic scan_none;
        logic scan_last;
    } status_t;

endpackage

/* sv/slla_ctrl.sv */
// ---------------------------------------------------------------------------
// slla_ctrl
// Sequencer: table clear after reset, lookup, load scan and commit.
// ---------------------------------------------------------------------------
`include "sticky_least_loaded_assign_assert.svh"

module slla_ctrl
    import slla_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (status.entry_valid || status.len_zero)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.scan_none)
                begin
                    state_next = ST_UPDATE;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // command decode
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
            end
            ST_IDLE:
            begin
                busy       = 1'b0;
                cmd.accept = start;
            end
            ST_LOOKUP:
            begin
                if (status.entry_valid)
                begin
                    cmd.post_hit = 1'b1;
                end
                else if (status.len_zero)
                begin
                    cmd.post_miss = 1'b1;
                end
                else
                begin
                    cmd.scan_init = 1'b1;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
            end
            ST_UPDATE:
            begin
                cmd.commit = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // checks
    `SLLA_ASSERT_NEXT(a_accept_to_lookup, cmd.accept, state_reg == ST_LOOKUP, "accept did not start a lookup")
    `SLLA_ASSERT_SAME(a_no_accept_in_clear, state_reg == ST_CLEAR, !cmd.accept && busy, "transaction taken during table clear")
    `SLLA_ASSERT_NEXT(a_update_to_idle, state_reg == ST_UPDATE, state_reg == ST_IDLE, "no idle after update")

endmodule

/* sv/slla_dp.sv */
// ---------------------------------------------------------------------------
// slla_dp
// Affinity table memory, engine load registers, min scan and result register.
// ---------------------------------------------------------------------------
`include "sticky_least_loaded_assign_assert.svh"

module slla_dp
    import slla_pkg::*;
#(
    parameter int MAX_ENGINES = 8,
    parameter int LOAD_BITS   = 48
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    output status_t              status,
    input  logic [SLOT_W-1:0]    key_slot,
    input  logic [LEN_W-1:0]     byte_length,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_W-1:0]     cfg_data,
    output logic                 done,
    output logic [OUT_ENG_W-1:0] engine_index,
    output logic                 newly_assigned,
    output logic                 lookup_miss
);

    localparam int ENG_W = (MAX_ENGINES > 1) ? $clog2(MAX_ENGINES) : 1;
    localparam int ENT_W = ENG_W + 1;

    // configuration
    logic [CFG_W-1:0] engine_count_reg;
    logic [ENG_W-1:0] last_idx;

    // captured transaction
    logic [SLOT_W-1:0] key_reg;
    logic [LEN_W-1:0]  len_reg;

    // affinity table: {valid, engine}
    logic [ENT_W-1:0]  aff_mem [KEY_SLOTS];
    logic [ENT_W-1:0]  rd_data_reg;
    logic [SLOT_W-1:0] clr_cnt_reg;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [ENT_W-1:0]  wr_data;

    // load scan
    logic [LOAD_BITS-1:0] load_reg [MAX_ENGINES];
    logic [ENG_W-1:0]     scan_idx_reg;
    logic [ENG_W-1:0]     best_idx_reg;
    logic [LOAD_BITS-1:0] best_load_reg;
    logic [LOAD_BITS:0]   load_sum;
    logic [LOAD_BITS-1:0] load_sat;

    // result register
    logic                 done_reg;
    logic [OUT_ENG_W-1:0] engine_index_reg;
    logic                 newly_reg;
    logic                 miss_reg;

    // configuration register, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            engine_count_reg <= CFG_W'(4);
        end
        else if (cfg_valid)
        begin
            engine_count_reg <= cfg_data;
        end
    end

    // last active engine index, count clamped to 1..MAX_ENGINES
    always_comb
    begin
        if (engine_count_reg == '0)
        begin
            last_idx = '0;
        end
        else if ({1'b0, engine_count_reg} > (CFG_W + 1)'(MAX_ENGINES))
        begin
            last_idx = ENG_W'(MAX_ENGINES - 1);
        end
        else
        begin
            last_idx = ENG_W'(engine_count_reg - CFG_W'(1));
        end
    end

    // transaction capture
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            key_reg <= key_slot;
            len_reg <= byte_length;
        end
    end

    // clear sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_wr)
        begin
            clr_cnt_reg <= clr_cnt_reg + SLOT_W'(1);
        end
    end

    // table write port select
    always_comb
    begin
        wr_en   = cmd.clr_wr || cmd.commit;
        wr_addr = cmd.clr_wr ? clr_cnt_reg : key_reg;
        wr_data = cmd.clr_wr ? '0 : {1'b1, best_idx_reg};
    end

    // affinity table memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            aff_mem[wr_addr] <= wr_data;
        end
        if (cmd.accept)
        begin
            rd_data_reg <= aff_mem[key_slot];
        end
    end

    // saturating load update
    always_comb
    begin
        load_sum = {1'b0, best_load_reg} + (LOAD_BITS + 1)'(len_reg);
        load_sat = load_sum[LOAD_BITS] ? '1 : load_sum[LOAD_BITS-1:0];
    end

    // min scan, one engine per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.scan_init)
        begin
            scan_idx_reg  <= ENG_W'(1);
            best_idx_reg  <= '0;
            best_load_reg <= load_reg[0];
        end
        else if (cmd.scan_step)
        begin
            scan_idx_reg <= scan_idx_reg + ENG_W'(1);
            if (load_reg[scan_idx_reg] < best_load_reg)
            begin
                best_idx_reg  <= scan_idx_reg;
                best_load_reg <= load_reg[scan_idx_reg];
            end
        end
    end

    // engine loads
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_ENGINES; i++)
            begin
                load_reg[i] <= '0;
            end
        end
        else if (cmd.commit)
        begin
            load_reg[best_idx_reg] <= load_sat;
        end
    end

    // result register, one-cycle strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.post_hit || cmd.post_miss || cmd.commit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.post_hit)
        begin
            engine_index_reg <= OUT_ENG_W'(rd_data_reg[ENG_W-1:0]);
            newly_reg        <= 1'b0;
            miss_reg         <= 1'b0;
        end
        else if (cmd.post_miss)
        begin
            engine_index_reg <= '0;
            newly_reg        <= 1'b0;
            miss_reg         <= 1'b1;
        end
        else if (cmd.commit)
        begin
            engine_index_reg <= OUT_ENG_W'(best_idx_reg);
            newly_reg        <= 1'b1;
            miss_reg         <= 1'b0;
        end
    end

    // status to controller
    always_comb
    begin
        status.clr_last    = (clr_cnt_reg == SLOT_W'(KEY_SLOTS - 1));
        status.entry_valid = rd_data_reg[ENT_W-1];
        status.len_zero    = (len_reg == '0);
        status.scan_none   = (last_idx == '0);
        status.scan_last   = (scan_idx_reg == last_idx);
    end

    assign done           = done_reg;
    assign engine_index   = engine_index_reg;
    assign newly_assigned = newly_reg;
    assign lookup_miss    = miss_reg;

    // checks
    `SLLA_ASSERT_SAME(a_miss_fields, done_reg && miss_reg, engine_index_reg == '0 && !newly_reg, "miss result carries an engine")
    `SLLA_ASSERT_NEXT(a_commit_result, cmd.commit, done_reg && newly_reg && !miss_reg, "commit did not post a new assignment")
    `SLLA_ASSERT_NEXT(a_no_result_after_accept, cmd.accept, !done_reg, "result posted one cycle after accept")

endmodule

/* sv/sticky_least_loaded_assign.sv */
// ---------------------------------------------------------------------------
// sticky_least_loaded_assign
// Sticky least-loaded engine assignment with a per-key affinity table.
// ---------------------------------------------------------------------------
// After reset the block sweeps the 1024-entry affinity table to invalid, one
// entry per cycle, and holds busy high until the sweep ends; configuration
// writes are taken at any time. A transaction is taken when start is high and
// busy is low. Its result appears on done for exactly one cycle and must be
// captured then: the receiver cannot stall. A key that already has an engine,
// or a zero-length lookup, gets its result from the registered table read
// through the result register. A new assignment first runs the load scan over
// the active engines, which compares one engine per cycle before the load and
// table are written back. busy is low again in the cycle that the result is
// shown, so a new transaction may start there.
// ---------------------------------------------------------------------------
module sticky_least_loaded_assign
    import slla_pkg::*;
#(
    parameter int MAX_ENGINES = 8,
    parameter int LOAD_BITS   = 48
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [SLOT_W-1:0]    key_slot,
    input  logic [LEN_W-1:0]     byte_length,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_W-1:0]     cfg_data,
    output logic                 done,
    output logic [OUT_ENG_W-1:0] engine_index,
    output logic                 newly_assigned,
    output logic                 lookup_miss
);

    cmd_t    cmd;
    status_t status;

    // sequencer
    slla_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    // table, loads and result
    slla_dp #(
        .MAX_ENGINES (MAX_ENGINES),
        .LOAD_BITS   (LOAD_BITS)
    ) u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .key_slot       (key_slot),
        .byte_length    (byte_length),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .done           (done),
        .engine_index   (engine_index),
        .newly_assigned (newly_assigned),
        .lookup_miss    (lookup_miss)
    );

endmodule

/* verif/sticky_least_loaded_assign_tb.sv */
// ---------------------------------------------------------------------------
// sticky_least_loaded_assign_tb
// Self-checking bench for the sticky least-loaded engine assignment block.
// A short table of directed requests and engine-count writes runs first.
// Random requests follow in several phases, each under its own engine count.
// Every result is compared with a local copy of the affinity table and the
// engine loads, or with the result that a typed directed row gives.
// ---------------------------------------------------------------------------
module sticky_least_loaded_assign_tb
    import slla_pkg::*;
();

    localparam int NUM_ENGINES = 8;
    localparam int LOAD_W      = 48;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 250;
    localparam int TAIL_CYCLES = 20;
    localparam int EXP_PTR_W   = 11;
    localparam int EXP_DEPTH   = 1 << EXP_PTR_W;

    typedef struct packed {
        logic [OUT_ENG_W-1:0] engine;
        logic                 fresh;
        logic                 miss;
    } assign_result_t;

    typedef enum logic {
        ROW_REQ,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [SLOT_W-1:0] slot;
        logic [LEN_W-1:0]  length;
        logic [CFG_W-1:0]  count;
        logic              typed;
        assign_result_t    res;
    } row_t;

    // directed requests and engine-count writes, in order
    localparam row_t DIRECTED [25] = '{
        '{ROW_REQ, 10'd0,    32'h0000_0000, 4'd0,  1'b1, '{3'd0, 1'b0, 1'b1}},
        '{ROW_REQ, 10'd1023, 32'hFFFF_FFFF, 4'd0,  1'b1, '{3'd0, 1'b1, 1'b0}},
        '{ROW_REQ, 10'd1023, 32'h0000_0000, 4'd0,  1'b1, '{3'd0, 1'b0, 1'b0}},
        '{ROW_REQ, 10'd1,    32'd1,         4'd0,  1'b0, '{3'd0, 1'b0, 1'b0}},
        '{ROW_REQ, 10'd2,    32'd2,         4'd0,  1'b0, '{3'd0, 1'b0, 1'b0}},
        '{ROW_REQ, 10'd3,    32'd3,         4'd0,  1'b0, '{3'd0, 1'b0, 1'b0}},
        '{ROW_REQ, 10'd4,    32'd1,         4'd0,  1'b0, '{3'd0, 1'b0, 1'b0}},
        '{ROW_CFG, 10'd0,    32'd0,         4'd0,  1'b0, '{3'd0, 1'b0, 1'b0}},
        '{ROW_REQ, 10'd10,   32'd5,         4'd0,  1'b1, '{3'd0, 1'b1, 1'b0}},
        '{ROW_CFG, 10'd0,    32'd0,         4'd15, 1'b0, '{3'd0, 1'b0, 1'b0}},
        '{ROW_REQ, 10'd11,   32'd7,         4'd0,  1'b0, '{3'd0, 1'b0, 1'b0}},
        '{ROW_REQ, 10'd12,   32'd7,         4'd0,  1'b0, '{3'd0, 1'b0, 1'b0}},
        '{ROW_REQ, 10'd13,   32'd7,         4'd0,  1'b0, '{3'd0, 1'b0, 1'b0}},
        '{ROW_REQ, 10'd14,   32'd7,         4'd0,  1'b0, '{3'd0, 1'b0, 1'b0}},
        '{ROW_CFG, 10'd0,    32'd0,         4'd1,  1'b0, '{3'd0, 1'b0, 1'b0}},
        '{ROW_REQ, 10'd14,   32'd0,         4'd0,  1'b0, '{3'd0, 1'b0, 1'b0}},
        '{ROW_REQ, 10'd14,   32'd100,       4'd0,  1'b0, '{3'd0, 1'b0, 1'b0}},
        '{ROW_CFG, 10'd0,    32'd0,         4'd9,  1'b0, '{3'd0, 1'b0, 1'b0}},
        '{ROW_REQ, 10'd1022, 32'h8000_0000, 4'd0,  1'b0, '{3'd0, 1'b0, 1'b0}},
        '{ROW_REQ, 10'd512,  32'h0000_0000, 4'd0,  1'b1, '{3'd0, 1'b0, 1'b1}},
        '{ROW_CFG, 10'd0,    32'd0,         4'd8,  1'b0, '{3'd0, 1'b0, 1'b0}},
        '{ROW_REQ, 10'd0,    32'd1,         4'd0,  1'b0, '{3'd0, 1'b0, 1'b0}},
        '{ROW_REQ, 10'h155,  32'h5555_5555, 4'd0,  1'b0, '{3'd0, 1'b0, 1'b0}},
        '{ROW_REQ, 10'h2AA,  32'hAAAA_AAAA, 4'd0,  1'b0, '{3'd0, 1'b0, 1'b0}},
        '{ROW_CFG, 10'd0,    32'd0,         4'd4,  1'b0, '{3'd0, 1'b0, 1'b0}}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [SLOT_W-1:0]    key_slot;
    logic [LEN_W-1:0]     byte_length;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data;
    logic                 done;
    logic [OUT_ENG_W-1:0] engine_index;
    logic                 newly_assigned;
    logic                 lookup_miss;

    // local copy of the block state
    logic                 affinity_valid  [KEY_SLOTS];
    logic [2:0]           affinity_engine [KEY_SLOTS];
    logic [LOAD_W-1:0]    engine_load     [NUM_ENGINES];
    logic [CFG_W-1:0]     engine_count;

    // expected results in order of acceptance
    assign_result_t       exp_fifo [EXP_DEPTH];
    logic [EXP_PTR_W-1:0] exp_wr_ptr;
    logic [EXP_PTR_W-1:0] exp_rd_ptr;
    int                   error_count;
    int                   idle_pct;

    sticky_least_loaded_assign u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .key_slot       (key_slot),
        .byte_length    (byte_length),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .done           (done),
        .engine_index   (engine_index),
        .newly_assigned (newly_assigned),
        .lookup_miss    (lookup_miss)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("[sticky_least_loaded_assign] ERROR");
        $finish;
    end

    // next assignment for one request, updating the local state
    function automatic assign_result_t predict_assignment(input logic [SLOT_W-1:0] slot,
                                                          input logic [LEN_W-1:0] length);
        assign_result_t    r;
        int                active;
        int                best;
        logic [LOAD_W-1:0] headroom;
        r = '0;
        if (affinity_valid[slot])
        begin
            r.engine = affinity_engine[slot];
        end
        else if (length == '0)
        begin
            r.miss = 1'b1;
        end
        else
        begin
            // zero engines behaves as one, anything above the maximum as the maximum
            active = (engine_count == 0) ? 1 :
                     (engine_count > NUM_ENGINES) ? NUM_ENGINES : int'(engine_count);
            best = 0;
            for (int i = 1; i < active; i++)
            begin
                if (engine_load[i] < engine_load[best])
                    best = i;
            end
            // saturating add
            headroom = {LOAD_W{1'b1}} - engine_load[best];
            if ({{(LOAD_W-LEN_W){1'b0}}, length} > headroom)
                engine_load[best] = {LOAD_W{1'b1}};
            else
                engine_load[best] = engine_load[best] + {{(LOAD_W-LEN_W){1'b0}}, length};
            affinity_valid[slot]  = 1'b1;
            affinity_engine[slot] = best[2:0];
            r.engine = best[2:0];
            r.fresh  = 1'b1;
        end
        return r;
    endfunction

    // one request transaction, with an optional idle burst in front
    task automatic issue_request(input logic [SLOT_W-1:0] slot, input logic [LEN_W-1:0] length,
                                 input logic typed, input assign_result_t typed_res);
        assign_result_t pred;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(13, 1))
            begin
                key_slot    <= SLOT_W'($urandom);
                byte_length <= LEN_W'($urandom);
                @(negedge clk);
            end
        end
        start       <= 1'b1;
        key_slot    <= slot;
        byte_length <= length;
        do
            @(posedge clk);
        while (busy);
        pred = predict_assignment(slot, length);
        exp_fifo[exp_wr_ptr] = typed ? typed_res : pred;
        exp_wr_ptr = exp_wr_ptr + EXP_PTR_W'(1);
        @(negedge clk);
    endtask

    // wait until every expected result has come back
    task automatic drain_results();
        start <= 1'b0;
        while (exp_wr_ptr != exp_rd_ptr)
            @(posedge clk);
        @(negedge clk);
    endtask

    // engine count write, only with the block idle
    task automatic write_engine_count(input logic [CFG_W-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        engine_count = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // random request: mostly new or repeated keys, a share of pure lookups
    task automatic random_request();
        logic [LEN_W-1:0] length;
        case ($urandom_range(9))
            0, 1, 2: length = '0;
            3:       length = {LEN_W{1'b1}};
            4:       length = LEN_W'($urandom_range(16, 1));
            default: length = $urandom;
        endcase
        issue_request(SLOT_W'($urandom), length, 1'b0, '0);
    endtask

    // result checker
    always @(posedge clk)
    begin
        assign_result_t want;
        if (rst_n && done)
        begin
            if (exp_wr_ptr == exp_rd_ptr)
            begin
                $display("%0t: unexpected result engine=%0d new=%0b miss=%0b", $time,
                         engine_index, newly_assigned, lookup_miss);
                error_count++;
            end
            else
            begin
                want = exp_fifo[exp_rd_ptr];
                exp_rd_ptr = exp_rd_ptr + EXP_PTR_W'(1);
                if (engine_index !== want.engine)
                begin
                    $display("%0t: engine_index expected %0d actual %0d", $time,
                             want.engine, engine_index);
                    error_count++;
                end
                if (newly_assigned !== want.fresh)
                begin
                    $display("%0t: newly_assigned expected %0b actual %0b", $time,
                             want.fresh, newly_assigned);
                    error_count++;
                end
                if (lookup_miss !== want.miss)
                begin
                    $display("%0t: lookup_miss expected %0b actual %0b", $time,
                             want.miss, lookup_miss);
                    error_count++;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        int          phase_cfg  [PHASES];
        int          phase_idle [PHASES];
        phase_cfg  = '{1, 8, 0, 15, 2, 3};
        phase_idle = '{30, 0, 15, 40, 20, 0};
        rst_n       = 1'b0;
        start       = 1'b0;
        key_slot    = '0;
        byte_length = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        error_count = 0;
        idle_pct    = 0;
        exp_wr_ptr  = '0;
        exp_rd_ptr  = '0;
        engine_count = 4'd4;
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            affinity_valid[i]  = 1'b0;
            affinity_engine[i] = '0;
        end
        for (int i = 0; i < NUM_ENGINES; i++)
            engine_load[i] = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table
        foreach (DIRECTED[i])
        begin
            if (DIRECTED[i].kind == ROW_CFG)
                write_engine_count(DIRECTED[i].count);
            else
                issue_request(DIRECTED[i].slot, DIRECTED[i].length, DIRECTED[i].typed,
                              DIRECTED[i].res);
        end

        // random phases, last one without idling
        phase_cfg[PHASES-1] = $urandom_range(15);
        for (int p = 0; p < PHASES; p++)
        begin
            write_engine_count(CFG_W'(phase_cfg[p]));
            idle_pct = phase_idle[p];
            repeat (PHASE_ITEMS)
                random_request();
        end

        // wind down
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("[sticky_least_loaded_assign] OK");
        else
            $display("[sticky_least_loaded_assign] ERROR");
        $finish;
    end

endmodule
